[rtl/ttp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared widths, codes and control/status structures of the tempo transport.
// ----------------------------------------------------------------------------
package ttp_pkg;

  // Position format and field widths
  localparam int POS_W             = 48;
  localparam int FRAC_BITS         = 32;
  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int SAMP_W            = 13;
  localparam int TEMPO_W           = 13;
  localparam int RATE_W            = 18;
  localparam int FUNC_W            = 3;

  // Increment division: (samples * tempo) << FRAC_BITS over 960 * rate
  localparam int SIXTEENTH_SEC_PER_MIN = 960;
  localparam int NUM_W  = SAMP_W + TEMPO_W;
  localparam int DEN_W  = 28;
  localparam int DIVN_W = NUM_W + FRAC_BITS;
  localparam int SUM_W  = POS_W + 1;
  localparam int CNT_W  = $clog2(DIVN_W);

  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] QUARTER_BEAT = POS_W'(64'd1 << (FRAC_BITS - 2));
  localparam logic [POS_W-1:0] LOOP_END_RST = POS_W'(64'd4 << FRAC_BITS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END    = 3'd4;

  // Transport functions
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLAY       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PAUSE      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REC_ON     = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_REC_OFF    = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SET_POS    = 3'd7;

  // Stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate;
    logic [TEMPO_W-1:0] tempo;
    logic               loop_en;
    logic [POS_W-1:0]   loop_start;
    logic [POS_W-1:0]   loop_end;
  } ttp_cfg_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic div_step;
    logic add;
    logic check;
    logic commit_sum;
    logic mod_step;
    logic mod_commit;
    logic load_out;
  } ttp_cmd_t;

  typedef struct packed {
    logic adv_play;
    logic step_last;
    logic wrap;
    logic out_free;
  } ttp_status_t;

endpackage
`default_nettype wire

[rtl/ttp_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttp_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module ttp_cfg import ttp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output ttp_cfg_t                   cfg
);

  ttp_cfg_t cfg_r;

  // Write the addressed register; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate <= RATE_W'(48000);
      cfg_r.tempo       <= TEMPO_W'(1920);
      cfg_r.loop_en     <= 1'b0;
      cfg_r.loop_start  <= '0;
      cfg_r.loop_end    <= LOOP_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: cfg_r.sample_rate <= cfg_wdata[RATE_W-1:0];
        CFG_TEMPO:       cfg_r.tempo       <= cfg_wdata[TEMPO_W-1:0];
        CFG_LOOP_ENABLE: cfg_r.loop_en     <= cfg_wdata[0];
        CFG_LOOP_START:  cfg_r.loop_start  <= cfg_wdata[POS_W-1:0];
        CFG_LOOP_END:    cfg_r.loop_end    <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/ttp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttp_datapath
// Transport state, bit-serial increment divider, loop modulo and result
// register.
// ----------------------------------------------------------------------------
module ttp_datapath import ttp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  ttp_cfg_t                   cfg,
  input  ttp_cmd_t                   cmd,
  output ttp_status_t                status,
  input  wire logic [FUNC_W-1:0]     in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // Captured item
  logic [FUNC_W-1:0] func_r;
  logic [SAMP_W-1:0] samp_r;
  logic [POS_W-1:0]  pv_r;

  // Transport state
  logic             play_r, rec_r;
  logic [POS_W-1:0] pos_r;

  // Divider
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  drem_r;
  logic [DIVN_W-1:0] nsh_r;
  logic [DIVN_W-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;

  // Sum and loop
  logic [SUM_W-1:0] sum_r;
  logic [POS_W-1:0] end_r, len_r;
  logic [SUM_W-1:0] dsh_r;
  logic [POS_W-1:0] mrem_r;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [SAMP_W-1:0] samp_in, samp_sat;
  logic [DEN_W:0]    dtrial, ddiff;
  logic              dge;
  logic [POS_W-1:0]  inc;
  logic [SUM_W-1:0]  qsum;
  logic [POS_W-1:0]  end_eff;
  logic              wrap;
  logic [SUM_W-1:0]  mtrial, mdiff, mnext;
  logic              mge;

  // Saturate the block length at capture
  assign samp_in  = in_tdata[SAMP_W-1:0];
  assign samp_sat = (samp_in > SAMP_W'(MAX_BLOCK_SAMPLES)) ?
                    SAMP_W'(MAX_BLOCK_SAMPLES) : samp_in;

  // One restoring division step
  assign dtrial = {drem_r, nsh_r[DIVN_W-1]};
  assign ddiff  = dtrial - {1'b0, den_r};
  assign dge    = (dtrial >= {1'b0, den_r});

  // Clamp the increment; a zero rate moves nothing
  always_comb begin
    if (cfg.sample_rate == '0) begin
      inc = '0;
    end else if (|quo_r[DIVN_W-1:POS_W]) begin
      inc = POS_MAX;
    end else begin
      inc = quo_r[POS_W-1:0];
    end
  end

  // Effective loop end: at least start plus a quarter beat, saturated
  assign qsum    = {1'b0, cfg.loop_start} + {1'b0, QUARTER_BEAT};
  always_comb begin
    end_eff = qsum[POS_W] ? POS_MAX : qsum[POS_W-1:0];
    if (cfg.loop_end > end_eff) begin
      end_eff = cfg.loop_end;
    end
  end

  assign wrap = cfg.loop_en && (len_r != '0) && (sum_r >= {1'b0, end_r});

  // One restoring modulo step
  assign mtrial = {mrem_r, dsh_r[SUM_W-1]};
  assign mdiff  = mtrial - {1'b0, len_r};
  assign mge    = (mtrial >= {1'b0, len_r});
  assign mnext  = mge ? mdiff : mtrial;

  // Transport state and control items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r <= 1'b0;
      rec_r  <= 1'b0;
      pos_r  <= '0;
    end else begin
      if (cmd.setup) begin
        unique case (func_r)
          FUNC_PLAY:    play_r <= 1'b1;
          FUNC_STOP: begin
            play_r <= 1'b0;
            rec_r  <= 1'b0;
            pos_r  <= '0;
          end
          FUNC_PAUSE:   play_r <= 1'b0;
          FUNC_TOGGLE:  play_r <= ~play_r;
          FUNC_REC_ON: begin
            play_r <= 1'b1;
            rec_r  <= 1'b1;
          end
          FUNC_REC_OFF: rec_r <= 1'b0;
          FUNC_SET_POS: pos_r <= pv_r[POS_W-1] ? '0 : pv_r;
          default: ;
        endcase
      end
      if (cmd.commit_sum) begin
        pos_r <= sum_r[POS_W] ? POS_MAX : sum_r[POS_W-1:0];
      end
      if (cmd.mod_commit) begin
        pos_r <= cfg.loop_start + mnext[POS_W-1:0];
      end
    end
  end

  // Item capture, divider, sum and modulo registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser;
      samp_r <= samp_sat;
      pv_r   <= in_tdata[SAMP_W +: POS_W];
    end
    if (cmd.setup) begin
      nsh_r  <= {NUM_W'(samp_r) * NUM_W'(cfg.tempo), {FRAC_BITS{1'b0}}};
      den_r  <= DEN_W'(cfg.sample_rate) * DEN_W'(SIXTEENTH_SEC_PER_MIN);
      drem_r <= '0;
      quo_r  <= '0;
      cnt_r  <= CNT_W'(DIVN_W - 1);
    end
    if (cmd.div_step) begin
      drem_r <= dge ? ddiff[DEN_W-1:0] : dtrial[DEN_W-1:0];
      quo_r  <= {quo_r[DIVN_W-2:0], dge};
      nsh_r  <= {nsh_r[DIVN_W-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.add) begin
      sum_r <= {1'b0, pos_r} + {1'b0, inc};
      end_r <= end_eff;
      len_r <= end_eff - cfg.loop_start;
    end
    if (cmd.check) begin
      dsh_r  <= sum_r - {1'b0, cfg.loop_start};
      mrem_r <= '0;
      cnt_r  <= CNT_W'(SUM_W - 1);
    end
    if (cmd.mod_step) begin
      mrem_r <= mnext[POS_W-1:0];
      dsh_r  <= {dsh_r[SUM_W-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  // Result register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= OUT_DATA_W'({rec_r, play_r, pos_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.adv_play  = (func_r == FUNC_ADVANCE) && play_r;
  assign status.step_last = (cnt_r == '0);
  assign status.wrap      = wrap;
  assign status.out_free  = !out_valid_r || out_tready;

endmodule
`default_nettype wire

[rtl/ttp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttp_ctrl
// Sequencer: decode, divide, add, loop check, modulo and result hand-off.
// ----------------------------------------------------------------------------
module ttp_ctrl import ttp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  ttp_status_t status,
  output ttp_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_ADD    = 7'b0001000,
    ST_CHECK  = 7'b0010000,
    ST_MOD    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } ttp_state_t;

  ttp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = status.adv_play ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.wrap) begin
          cmd.check = 1'b1;
          state_nxt = ST_MOD;
        end else begin
          cmd.commit_sum = 1'b1;
          state_nxt      = ST_FINISH;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.step_last) begin
          cmd.mod_commit = 1'b1;
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/tempo_transport_position.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: control items, and advance items while stopped, pass from capture
// through setup to the result; an advance item while playing also runs the
// 58-step bit-serial increment divider, and the 49-step loop modulo on wrap.
// Throughput: one item in flight; the next is taken once the result is loaded
// into the output register, which then waits for its transfer on its own.
// Reset: synchronous, active low; restores registers, clears state and output.
// ----------------------------------------------------------------------------
// tempo_transport_position
// Song transport keeping a Q16.32 beat position with play and record flags.
// ----------------------------------------------------------------------------
module tempo_transport_position import ttp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [2:0] func
  input  wire logic [FUNC_W-1:0]     in_tuser,
  // [12:0] num_samples, [60:13] position_value, [63:61] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [47:0] position, [48] playing, [49] recording, [55:50] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ttp_cfg_t    cfg;
  ttp_cmd_t    cmd;
  ttp_status_t status;

  ttp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ttp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
